FILE: rtl/afu_pkg.sv
package afu_pkg;

   localparam int FRAC_BITS_DEF      = 12;
   localparam int TABLE_SEGMENTS_DEF = 64;

   // Sigmoid values are unsigned Q30; 1.0 needs bit 30.
   localparam int Q30_W = 31;
   // Segment slope in Q30; the steepest segment at the coarsest table stays below 2^27.
   localparam int DIFF_W = 28;
   localparam int SAMPLE_W = 16;

   typedef enum logic [1:0] {
      ACT_SIGMOID = 2'd0,
      ACT_TANH    = 2'd1,
      ACT_RELU    = 2'd2
   } act_mode_type;

   typedef enum logic {
      CSR_ACT_MODE     = 1'b0,
      CSR_DERIV_SELECT = 1'b1
   } csr_index_type;

   // Shift-and-subtract division, used only while building the table.
   function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-8/seg) in Q31 by a truncated Taylor series.
   function automatic longint unsigned sig_exp_step(int seg);
      longint unsigned a;
      longint unsigned term;
      longint sum;
      a = udiv((64'd8 << 31) + (64'(seg) >> 1), 64'(seg));
      term = 64'd1 << 31;
      sum = 64'sd1 <<< 31;
      for (int n = 1; n <= 24; n++) begin
         term = udiv((term * a) >> 31, 64'(n));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return longint'(sum);
   endfunction

   // Table point k: sig(8k/seg) in Q30.
   function automatic logic [Q30_W-1:0] sig_entry(int seg, int k);
      longint unsigned ea;
      longint unsigned e;
      longint unsigned d;
      ea = sig_exp_step(seg);
      e = 64'd1 << 31;
      for (int j = 1; j <= k; j++) begin
         e = (e * ea + (64'd1 << 30)) >> 31;
      end
      d = (64'd1 << 31) + e;
      return Q30_W'(udiv((64'd1 << 61) + (d >> 1), d));
   endfunction

endpackage

FILE: rtl/activation_function_unit.sv
// Activation unit: one signed sample per beat in, one result beat out. It takes a new sample
// in every clock cycle, so busy is never raised, and each result appears on rsp_sample_out
// with rsp_valid high for one cycle once its start beat has passed through the five
// stages. These are the registered read of the sigmoid segment table, the slope
// interpolation multiply, the sigmoid/tanh assembly, the 32 by 32 derivative multiply,
// and the final rounding. Results cannot be held off, so the consumer must take every beat
// as it appears. Mode and derivative select should only be changed with nothing in flight.
module activation_function_unit
   import afu_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int TABLE_SEGMENTS = TABLE_SEGMENTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [1:0]                 csr_wdata
);

   localparam int SH      = FRAC_BITS + 3;
   localparam int AW      = 18;
   localparam int SEG_W   = $clog2(TABLE_SEGMENTS + 1);
   localparam int PW      = AW + SEG_W;
   localparam int IW      = $clog2(TABLE_SEGMENTS + 1);
   localparam int EW      = DIFF_W + Q30_W;
   localparam int MW      = DIFF_W + SH;
   localparam int RW      = 34;
   localparam logic [AW-1:0]        SAT_LIM = AW'(8 << FRAC_BITS);
   localparam logic [Q30_W-1:0]     ONE_Q30 = Q30_W'(1) << 30;
   localparam logic signed [31:0]   ONE_S32 = 32'sd1 <<< 30;
   localparam logic [MW:0]          HALF_SEG = (MW + 1)'(1) << (SH - 1);
   localparam logic signed [RW-1:0] HALF_OUT = RW'(1) <<< (29 - FRAC_BITS);

   typedef struct packed {
      logic [1:0]                 mode;
      logic                       der;
      logic signed [SAMPLE_W-1:0] x;
   } ctl_type;

   // Each table row holds the segment start value and its rise to the next point.
   logic [EW-1:0] rom_mem [TABLE_SEGMENTS + 1];

   for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_rom
      localparam logic [Q30_W-1:0] LO = sig_entry(TABLE_SEGMENTS, k);
      localparam logic [Q30_W-1:0] HI =
         (k < TABLE_SEGMENTS) ? sig_entry(TABLE_SEGMENTS, k + 1) : LO;
      localparam logic [DIFF_W-1:0] DF = (HI > LO) ? DIFF_W'(HI - LO) : '0;
      assign rom_mem[k] = {DF, LO};
   end

   logic [1:0]    act_mode_ff;
   logic          deriv_ff;
   logic [3:0]    vld_ff;
   logic          rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_out_ff;

   // Stage 0: table address from the clamped magnitude.
   logic                 accept;
   logic signed [AW-1:0] s0_v;
   logic [AW-1:0]        s0_mag;
   logic [AW-1:0]        s0_mag_cl;
   logic [PW-1:0]        s0_pos;
   logic [IW-1:0]        rom_idx;
   ctl_type              s0_ctl_in;

   // Stage 1: table row.
   logic [EW-1:0]        rom_q_ff;
   logic [SH-1:0]        s1_frac_ff;
   logic                 s1_neg_ff;
   ctl_type              s1_ctl_ff;
   logic [MW-1:0]        s2_prod_in;

   // Stage 2: interpolated sigmoid.
   logic [MW-1:0]        s2_prod_ff;
   logic [Q30_W-1:0]     s2_lo_ff;
   logic                 s2_neg_ff;
   ctl_type              s2_ctl_ff;
   logic [MW:0]          s2_step_sum;
   logic [Q30_W-1:0]     s2_pos_sig;
   logic [Q30_W-1:0]     s2_sig;
   logic [Q30_W-1:0]     s2_sig_c;
   logic signed [31:0]   s2_tanh;
   logic signed [31:0]   s2_y_in;
   logic signed [31:0]   s2_opa_in;
   logic signed [31:0]   s2_opb_in;

   // Stage 3: derivative product multiply.
   logic signed [31:0]   s3_y_ff;
   logic signed [31:0]   s3_opa_ff;
   logic signed [31:0]   s3_opb_ff;
   ctl_type              s3_ctl_ff;
   logic signed [63:0]   s3_prod_in;

   // Stage 4: derivative assembly and rounding.
   logic signed [63:0]   s4_prod_ff;
   logic signed [31:0]   s4_y_ff;
   ctl_type              s4_ctl_ff;
   logic signed [31:0]   s4_hi;
   logic signed [31:0]   s4_q30;
   logic signed [RW-1:0] s4_round;
   logic signed [SAMPLE_W-1:0] s4_smooth;
   logic signed [SAMPLE_W-1:0] s4_relu;
   logic signed [SAMPLE_W-1:0] rsp_sample_out_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff <= ACT_SIGMOID;
         deriv_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACT_MODE:     act_mode_ff <= csr_wdata;
            CSR_DERIV_SELECT: deriv_ff    <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      s0_v = (act_mode_ff == ACT_TANH) ? (AW'(req_sample_in) <<< 1) : AW'(req_sample_in);
      s0_mag = s0_v[AW-1] ? AW'(-s0_v) : AW'(s0_v);
      s0_mag_cl = (s0_mag > SAT_LIM) ? SAT_LIM : s0_mag;
      s0_pos = PW'(s0_mag_cl) * PW'(TABLE_SEGMENTS);
      rom_idx = IW'(s0_pos >> SH);
      s0_ctl_in.mode = act_mode_ff;
      s0_ctl_in.der  = deriv_ff;
      s0_ctl_in.x    = req_sample_in;
   end

   always_ff @(posedge clock) begin
      rom_q_ff   <= rom_mem[rom_idx];
      s1_frac_ff <= s0_pos[SH-1:0];
      s1_neg_ff  <= s0_v[AW-1];
      s1_ctl_ff  <= s0_ctl_in;
   end

   assign s2_prod_in = MW'(rom_q_ff[EW-1:Q30_W]) * MW'(s1_frac_ff);

   always_ff @(posedge clock) begin
      s2_prod_ff <= s2_prod_in;
      s2_lo_ff   <= rom_q_ff[Q30_W-1:0];
      s2_neg_ff  <= s1_neg_ff;
      s2_ctl_ff  <= s1_ctl_ff;
   end

   always_comb begin
      s2_step_sum = (MW + 1)'(s2_prod_ff) + HALF_SEG;
      s2_pos_sig  = s2_lo_ff + Q30_W'(s2_step_sum >> SH);
      s2_sig      = s2_neg_ff ? (ONE_Q30 - s2_pos_sig) : s2_pos_sig;
      s2_sig_c    = ONE_Q30 - s2_sig;
      s2_tanh     = $signed(32'(s2_sig)) - $signed(32'(s2_sig_c));
      if (s2_ctl_ff.mode == ACT_TANH) begin
         s2_y_in   = s2_tanh;
         s2_opa_in = s2_tanh;
         s2_opb_in = s2_tanh;
      end else begin
         s2_y_in   = $signed(32'(s2_sig));
         s2_opa_in = $signed(32'(s2_sig));
         s2_opb_in = $signed(32'(s2_sig_c));
      end
   end

   always_ff @(posedge clock) begin
      s3_y_ff   <= s2_y_in;
      s3_opa_ff <= s2_opa_in;
      s3_opb_ff <= s2_opb_in;
      s3_ctl_ff <= s2_ctl_ff;
   end

   assign s3_prod_in = 64'(s3_opa_ff) * 64'(s3_opb_ff);

   always_ff @(posedge clock) begin
      s4_prod_ff <= s3_prod_in;
      s4_y_ff    <= s3_y_ff;
      s4_ctl_ff  <= s3_ctl_ff;
   end

   always_comb begin
      // Both derivative products are non-negative, so the top bits are the floored value.
      s4_hi = $signed(s4_prod_ff[61:30]);
      if (!s4_ctl_ff.der) begin
         s4_q30 = s4_y_ff;
      end else if (s4_ctl_ff.mode == ACT_TANH) begin
         s4_q30 = ONE_S32 - s4_hi;
      end else begin
         s4_q30 = s4_hi;
      end
      s4_round  = (RW'(s4_q30) + HALF_OUT) >>> (30 - FRAC_BITS);
      s4_smooth = s4_round[SAMPLE_W-1:0];
      if (s4_ctl_ff.der) begin
         s4_relu = (s4_ctl_ff.x > 0) ? (SAMPLE_W'(1) <<< FRAC_BITS) : '0;
      end else begin
         s4_relu = (s4_ctl_ff.x < 0) ? '0 : s4_ctl_ff.x;
      end
      unique case (s4_ctl_ff.mode)
         ACT_SIGMOID, ACT_TANH: rsp_sample_out_in = s4_smooth;
         ACT_RELU:              rsp_sample_out_in = s4_relu;
         default:               rsp_sample_out_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[2:0], accept};
         rsp_valid_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted sample produced no result five cycles later");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result beat without a matching accepted sample");

   a_rom_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (32'(rom_idx) <= TABLE_SEGMENTS))
      else $error("segment table index beyond the last point");

   a_sig_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && s3_ctl_ff.mode == ACT_SIGMOID) |->
         (s3_y_ff >= 0 && s3_y_ff <= ONE_S32))
      else $error("sigmoid outside the unit interval");

   a_deriv_sign: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && s4_ctl_ff.der &&
         (s4_ctl_ff.mode == ACT_SIGMOID || s4_ctl_ff.mode == ACT_TANH)) |->
         (s4_prod_ff >= 0))
      else $error("derivative product went negative");

endmodule
